// File: sv/pbssr_pkg.sv
// ----------------------------------------------------------------------------
// pbssr_pkg: shared types and constants
// Item layouts, queue status and outcome codes for the per-beam signal
// strength recorder.
// ----------------------------------------------------------------------------
package pbssr_pkg;

    localparam logic [15:0] BEACON_TYPE_RESET = 16'h000C;
    localparam int BEAM_SECTOR_LSB = 26;
    localparam int STRENGTH_SHIFT  = 4;
    localparam int STAMP_W  = 32;
    localparam int FRAMES_W = 32;

    localparam logic [1:0] OUTCOME_IGNORED   = 2'd0;
    localparam logic [1:0] OUTCOME_DUPLICATE = 2'd1;
    localparam logic [1:0] OUTCOME_RECORDED  = 2'd2;

    typedef struct packed {
        logic [31:0] header_word_zero;
        logic [31:0] header_word_two;
        logic [31:0] header_word_three;
        logic [31:0] header_word_four;
        logic [31:0] header_word_five;
        logic [31:0] strength_raw;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [6:0]  beam_number;
        logic [31:0] frame_count;
        logic [3:0]  slot_written;
        logic [15:0] sample_written;
    } out_item_t;

    typedef struct packed {
        logic        type_ok;
        logic [6:0]  beam;
        logic [31:0] stamp;
        logic [27:0] strength_scaled;
    } work_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

// File: sv/pbssr_ram.sv
// ----------------------------------------------------------------------------
// pbssr_ram: generic single-port-write memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pbssr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/pbssr_front.sv
// ----------------------------------------------------------------------------
// pbssr_front: input classification
// Holds the accepted frame type, checks the frame type, extracts the beam
// index, timestamp and scaled strength, and pushes the work item.
// ----------------------------------------------------------------------------
module pbssr_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [15:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  pbssr_pkg::in_item_t    in_data,
    input  pbssr_pkg::queue_stat_t q_stat,
    output logic                   q_push,
    output pbssr_pkg::work_item_t  q_wr_item
);

    logic [15:0] beacon_type_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beacon_type_reg <= pbssr_pkg::BEACON_TYPE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            beacon_type_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = q_stat.full;
    assign q_push    = in_valid && !q_stat.full;

    always_comb
    begin
        q_wr_item.type_ok = (in_data.header_word_zero[15:0] == beacon_type_reg);
        q_wr_item.beam    = {in_data.header_word_five[0],
                             in_data.header_word_four[pbssr_pkg::BEAM_SECTOR_LSB +: 6]};
        q_wr_item.stamp   = {in_data.header_word_three[15:0],
                             in_data.header_word_two[31:16]};
        q_wr_item.strength_scaled =
            in_data.strength_raw[31:pbssr_pkg::STRENGTH_SHIFT];
    end

endmodule

// File: sv/pbssr_queue.sv
// ----------------------------------------------------------------------------
// pbssr_queue: two-entry work queue
// Decouples the classifying front from the per-beam update stage.
// ----------------------------------------------------------------------------
module pbssr_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  pbssr_pkg::work_item_t  wr_item,
    input  logic                   pop,
    output pbssr_pkg::work_item_t  rd_item,
    output pbssr_pkg::queue_stat_t stat
);

    pbssr_pkg::work_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item    = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == 2'd0);
    assign stat.full  = (count_reg == 2'd2);

endmodule

// File: sv/pbssr_back.sv
// ----------------------------------------------------------------------------
// pbssr_back: per-beam update stage
// Reads the beam state, drops duplicates, updates stamp, count and ring head,
// writes the sample ring and holds the result in the output register.
// ----------------------------------------------------------------------------
module pbssr_back #(
    parameter int BEAM_COUNT  = 128,
    parameter int RING_SLOTS  = 12,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pbssr_pkg::work_item_t  q_rd_item,
    input  pbssr_pkg::queue_stat_t q_stat,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output pbssr_pkg::out_item_t   out_data
);

    localparam int ENTRY_W = $clog2(BEAM_COUNT);
    localparam int HEAD_W  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int STATE_W = pbssr_pkg::STAMP_W + pbssr_pkg::FRAMES_W + HEAD_W;
    localparam int RING_DEPTH = BEAM_COUNT * RING_SLOTS;
    localparam int RING_AW = $clog2(RING_DEPTH);

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_EXEC = 2'b10
    } back_state_t;

    back_state_t             state_reg;
    back_state_t             state_next;
    pbssr_pkg::work_item_t   work_reg;
    logic [ENTRY_W-1:0]      entry_reg;
    logic                    hit_valid_reg;
    logic [BEAM_COUNT-1:0]   beam_valid_reg;
    logic [BEAM_COUNT-1:0]   beam_valid_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    pbssr_pkg::out_item_t    out_data_reg;
    pbssr_pkg::out_item_t    out_data_next;

    logic [ENTRY_W-1:0]      head_entry;
    logic                    out_free;
    logic                    rd_en;
    logic                    finish;
    logic                    commit;
    logic [STATE_W-1:0]      rd_word;
    logic [STATE_W-1:0]      state_rd_data;
    logic [STATE_W-1:0]      wr_word;
    logic [31:0]             old_stamp;
    logic [31:0]             old_frames;
    logic [HEAD_W-1:0]       old_head;
    logic [HEAD_W-1:0]       head;
    logic [HEAD_W-1:0]       head_next;
    logic [31:0]             head_ext;
    logic [31:0]             new_frames;
    logic                    duplicate;
    logic [SAMPLE_BITS-1:0]  sample;
    logic [31:0]             sample_ext;
    logic [RING_AW-1:0]      ring_addr;

    function automatic logic [ENTRY_W-1:0] beam_entry(input logic [6:0] beam);
        logic [ENTRY_W-1:0] result;
        result = '0;
        for (int i = 0; i < 128; i++)
        begin
            if (beam == 7'(i))
            begin
                result = ENTRY_W'(i % BEAM_COUNT);
            end
        end
        return result;
    endfunction

    assign head_entry = beam_entry(q_rd_item.beam);
    assign out_free   = !out_valid_reg || !out_stall;
    assign rd_en      = (state_reg == BK_IDLE) && !q_stat.empty;
    assign q_pop      = rd_en;
    assign finish     = (state_reg == BK_EXEC) && out_free;

    always_comb
    begin
        rd_word    = hit_valid_reg ? state_rd_data : '0;
        old_stamp  = rd_word[STATE_W-1 -: pbssr_pkg::STAMP_W];
        old_frames = rd_word[HEAD_W +: pbssr_pkg::FRAMES_W];
        old_head   = rd_word[HEAD_W-1:0];
        head       = (32'(old_head) >= 32'(RING_SLOTS)) ? '0 : old_head;
        head_next  = (32'(head) + 32'd1 >= 32'(RING_SLOTS)) ? '0 : head + HEAD_W'(1);
        head_ext   = 32'(head);
        new_frames = old_frames + 32'd1;
        duplicate  = (old_stamp == work_reg.stamp);
        sample     = SAMPLE_BITS'({4'b0000, work_reg.strength_scaled});
        sample_ext = 32'(sample);
        ring_addr  = RING_AW'(32'(entry_reg) * 32'(RING_SLOTS) + head_ext);
        commit     = finish && work_reg.type_ok && !duplicate;
        wr_word    = {work_reg.stamp, new_frames, head_next};
    end

    always_comb
    begin
        state_next      = state_reg;
        beam_valid_next = beam_valid_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (rd_en)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (finish)
                begin
                    state_next     = BK_IDLE;
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    if (!work_reg.type_ok)
                    begin
                        out_data_next.outcome = pbssr_pkg::OUTCOME_IGNORED;
                    end
                    else if (duplicate)
                    begin
                        out_data_next.outcome     = pbssr_pkg::OUTCOME_DUPLICATE;
                        out_data_next.beam_number = work_reg.beam;
                    end
                    else
                    begin
                        out_data_next.outcome        = pbssr_pkg::OUTCOME_RECORDED;
                        out_data_next.beam_number    = work_reg.beam;
                        out_data_next.frame_count    = new_frames;
                        out_data_next.slot_written   = head_ext[3:0];
                        out_data_next.sample_written = sample_ext[15:0];
                        beam_valid_next[entry_reg]   = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            beam_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            beam_valid_reg <= beam_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (rd_en)
        begin
            work_reg      <= q_rd_item;
            entry_reg     <= head_entry;
            hit_valid_reg <= beam_valid_reg[head_entry];
        end
    end

    pbssr_ram #(
        .WIDTH (STATE_W),
        .DEPTH (BEAM_COUNT)
    ) u_beam_state (
        .clk     (clk),
        .wr_en   (commit),
        .wr_addr (entry_reg),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (head_entry),
        .rd_data (state_rd_data)
    );

    pbssr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_sample_ring (
        .clk     (clk),
        .wr_en   (commit),
        .wr_addr (ring_addr),
        .wr_data (sample),
        .rd_en   (1'b0),
        .rd_addr (ring_addr),
        .rd_data ()
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: sv/per_beam_signal_strength_recorder.sv
// ----------------------------------------------------------------------------
// per_beam_signal_strength_recorder: top level
// Records per-beam timestamps, frame counts and strength samples.
// ----------------------------------------------------------------------------
// Each frame event is classified on entry and queued (two entries); the update
// stage then handles one item at a time: it reads the beam's state memory,
// then checks for a duplicate, writes the updated state and sample and loads
// the output register, waiting there while a held result is stalled; a new
// item is popped only after the last one has finished. Beam state is cleared
// at reset by one valid bit per beam, so there is no clearing pass and items
// are taken right after reset.
module per_beam_signal_strength_recorder #(
    parameter int BEAM_COUNT  = 128,
    parameter int RING_SLOTS  = 12,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pbssr_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pbssr_pkg::out_item_t out_data
);

    pbssr_pkg::queue_stat_t q_stat;
    pbssr_pkg::work_item_t  q_wr_item;
    pbssr_pkg::work_item_t  q_rd_item;
    logic                   q_push;
    logic                   q_pop;

    pbssr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_wr_item (q_wr_item)
    );

    pbssr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (q_wr_item),
        .pop     (q_pop),
        .rd_item (q_rd_item),
        .stat    (q_stat)
    );

    pbssr_back #(
        .BEAM_COUNT  (BEAM_COUNT),
        .RING_SLOTS  (RING_SLOTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd_item (q_rd_item),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // An accepted input transfer always leaves at least one item queued.
    a_queue_holds_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !q_stat.empty
    ) else $error("queue empty right after an input transfer");

    // An ignored frame reports no beam state at all.
    a_ignored_clean: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.outcome == pbssr_pkg::OUTCOME_IGNORED) |->
        (out_data.beam_number == 7'd0 && out_data.frame_count == 32'd0 &&
         out_data.slot_written == 4'd0 && out_data.sample_written == 16'd0)
    ) else $error("ignored frame carries beam data");

    // The update stage does not pop again until it has finished the popped item.
    a_pop_spacing: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_pop |=> !q_pop
    ) else $error("back-to-back pops from the work queue");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: per-beam signal strength recorder testbench
// Sends frame events through the input channel with random gaps, checks
// every result against a per-beam prediction of stamp, count and ring slot,
// and rewrites the frame type register between phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int BEAM_COUNT  = 128;
    localparam int RING_SLOTS  = 12;
    localparam int SAMPLE_BITS = 16;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [15:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    pbssr_pkg::in_item_t  in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    pbssr_pkg::out_item_t out_data;

    logic [15:0] beacon_type_model;
    logic [31:0] stamp_model [BEAM_COUNT];
    logic [31:0] count_model [BEAM_COUNT];
    logic [3:0]  head_model [BEAM_COUNT];

    pbssr_pkg::out_item_t pending_results [$];
    pbssr_pkg::out_item_t oldest_result;
    int error_count = 0;
    int recorded_total = 0;
    int duplicate_total = 0;
    int ignored_total = 0;
    int type_settings = 0;
    int in_gap_max = 4;
    int out_gap_max = 4;

    per_beam_signal_strength_recorder #(
        .BEAM_COUNT (BEAM_COUNT),
        .RING_SLOTS (RING_SLOTS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic pbssr_pkg::out_item_t predict_frame(input pbssr_pkg::in_item_t frame);
        pbssr_pkg::out_item_t result;
        logic [6:0] beam;
        logic [31:0] stamp;
        result = '0;
        result.outcome = pbssr_pkg::OUTCOME_IGNORED;
        if (frame.header_word_zero[15:0] != beacon_type_model)
        begin
            return result;
        end
        beam = {frame.header_word_five[0], frame.header_word_four[31:26]};
        stamp = {frame.header_word_three[15:0], frame.header_word_two[31:16]};
        result.beam_number = beam;
        if (stamp == stamp_model[beam])
        begin
            result.outcome = pbssr_pkg::OUTCOME_DUPLICATE;
            return result;
        end
        stamp_model[beam] = stamp;
        count_model[beam] = count_model[beam] + 32'd1;
        result.outcome = pbssr_pkg::OUTCOME_RECORDED;
        result.frame_count = count_model[beam];
        result.slot_written = head_model[beam];
        result.sample_written = frame.strength_raw[19:4];
        head_model[beam] = (head_model[beam] == 4'(RING_SLOTS - 1)) ? 4'd0
                                                                    : head_model[beam] + 4'd1;
        return result;
    endfunction

    function automatic pbssr_pkg::in_item_t build_frame(input logic [15:0] beacon_type,
                                                        input logic [6:0] beam,
                                                        input logic [31:0] stamp,
                                                        input logic [31:0] strength);
        pbssr_pkg::in_item_t frame;
        frame.header_word_zero  = $urandom();
        frame.header_word_two   = $urandom();
        frame.header_word_three = $urandom();
        frame.header_word_four  = $urandom();
        frame.header_word_five  = $urandom();
        frame.header_word_zero[15:0]   = beacon_type;
        frame.header_word_two[31:16]   = stamp[15:0];
        frame.header_word_three[15:0]  = stamp[31:16];
        frame.header_word_four[31:26]  = beam[5:0];
        frame.header_word_five[0]      = beam[6];
        frame.strength_raw             = strength;
        return frame;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] expected_value,
                                   input logic [31:0] actual_value);
        $display("%0t: %s mismatch, expected %0h, actual %0h",
                 $realtime, field, expected_value, actual_value);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            pending_results.push_back(predict_frame(in_data));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0h",
                         $realtime, out_data);
                error_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                case (oldest_result.outcome)
                    pbssr_pkg::OUTCOME_RECORDED:  recorded_total++;
                    pbssr_pkg::OUTCOME_DUPLICATE: duplicate_total++;
                    default:                      ignored_total++;
                endcase
                if (out_data.outcome != oldest_result.outcome)
                    report_mismatch("outcome", 32'(oldest_result.outcome),
                                    32'(out_data.outcome));
                if (out_data.beam_number != oldest_result.beam_number)
                    report_mismatch("beam_number", 32'(oldest_result.beam_number),
                                    32'(out_data.beam_number));
                if (out_data.frame_count != oldest_result.frame_count)
                    report_mismatch("frame_count", oldest_result.frame_count,
                                    out_data.frame_count);
                if (out_data.slot_written != oldest_result.slot_written)
                    report_mismatch("slot_written", 32'(oldest_result.slot_written),
                                    32'(out_data.slot_written));
                if (out_data.sample_written != oldest_result.sample_written)
                    report_mismatch("sample_written", 32'(oldest_result.sample_written),
                                    32'(out_data.sample_written));
            end
        end
    end

    always
    begin
        int wait_cycles;
        wait_cycles = $urandom_range(0, out_gap_max);
        repeat (wait_cycles)
        begin
            @(negedge clk);
            out_stall <= 1'b1;
        end
        @(negedge clk);
        out_stall <= 1'b0;
        do @(posedge clk); while (!(rst_n && out_valid && !out_stall));
    end

    task automatic send_frame(input pbssr_pkg::in_item_t frame);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= frame;
        do @(posedge clk); while (!(in_valid && !in_stall));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_beacon_type(input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        beacon_type_model = value;
        type_settings++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        pbssr_pkg::in_item_t frame;
        send_frame(build_frame(pbssr_pkg::BEACON_TYPE_RESET, 7'd0, 32'd0, 32'h0000_1234));
        send_frame(build_frame(pbssr_pkg::BEACON_TYPE_RESET, 7'd0, 32'd1, 32'd0));
        send_frame(build_frame(pbssr_pkg::BEACON_TYPE_RESET, 7'd0, 32'd1, 32'hFFFF_FFFF));
        send_frame(build_frame(pbssr_pkg::BEACON_TYPE_RESET + 16'd1, 7'd0, 32'd2, 32'd5));
        frame = '1;
        send_frame(frame);
        frame = '0;
        send_frame(frame);
        wait_for_results();
    endtask

    task automatic test_field_extremes();
        pbssr_pkg::in_item_t frame;
        frame = '1;
        frame.header_word_zero[15:0] = pbssr_pkg::BEACON_TYPE_RESET;
        send_frame(frame);
        frame = '0;
        frame.header_word_zero[15:0] = pbssr_pkg::BEACON_TYPE_RESET;
        frame.header_word_two[31:16] = 16'h0001;
        send_frame(frame);
        send_frame(build_frame(pbssr_pkg::BEACON_TYPE_RESET, 7'd64, 32'h8000_0000,
                               32'h0000_000F));
        send_frame(build_frame(pbssr_pkg::BEACON_TYPE_RESET, 7'd63, 32'h0000_FFFF,
                               32'h0000_0010));
        send_frame(build_frame(pbssr_pkg::BEACON_TYPE_RESET, 7'd127, 32'hFFFF_0000,
                               32'h000F_FFFF));
        send_frame(build_frame(pbssr_pkg::BEACON_TYPE_RESET, 7'd1, 32'h1234_5678,
                               32'h0010_0000));
        frame = build_frame(pbssr_pkg::BEACON_TYPE_RESET, 7'd2, 32'd9, 32'h8000_0000);
        frame.header_word_five[31:1] = '1;
        send_frame(frame);
        wait_for_results();
    endtask

    task automatic test_ring_wrap();
        for (int n = 0; n < RING_SLOTS + 2; n++)
        begin
            send_frame(build_frame(pbssr_pkg::BEACON_TYPE_RESET, 7'd5, 32'd100 + n,
                                   $urandom()));
        end
        wait_for_results();
    endtask

    task automatic test_type_register();
        write_beacon_type(16'h0000);
        send_frame(build_frame(16'h0000, 7'd10, $urandom(), $urandom()));
        send_frame(build_frame(16'hFFFF, 7'd10, $urandom(), $urandom()));
        send_frame(build_frame(pbssr_pkg::BEACON_TYPE_RESET, 7'd10, $urandom(), $urandom()));
        wait_for_results();
        write_beacon_type(16'hFFFF);
        send_frame(build_frame(16'hFFFF, 7'd11, $urandom(), $urandom()));
        send_frame(build_frame(16'h0000, 7'd11, $urandom(), $urandom()));
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        logic [15:0] phase_type [4];
        int          in_gaps [4];
        int          out_gaps [4];
        pbssr_pkg::in_item_t frame;
        int          pick;
        logic [6:0]  beam;
        logic [31:0] stamp;
        logic [31:0] strength;
        phase_type = '{16'($urandom()), 16'h0000, 16'hFFFF, pbssr_pkg::BEACON_TYPE_RESET};
        in_gaps = '{4, 0, 0, 4};
        out_gaps = '{4, 0, 4, 0};
        for (int phase = 0; phase < 4; phase++)
        begin
            write_beacon_type(phase_type[phase]);
            in_gap_max = in_gaps[phase];
            out_gap_max = out_gaps[phase];
            for (int n = 0; n < 350; n++)
            begin
                pick = $urandom_range(0, 99);
                beam = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 7))
                                                   : 7'($urandom_range(0, 127));
                stamp = $urandom();
                strength = $urandom();
                if (pick < 5)
                    stamp = stamp_model[beam];
                else if (pick < 25)
                    stamp = 32'd0;
                if ($urandom_range(0, 9) == 0)
                    strength = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
                if (pick >= 25 && pick < 45)
                    stamp = stamp_model[beam];
                if (pick >= 90)
                begin
                    frame.header_word_zero  = $urandom();
                    frame.header_word_two   = $urandom();
                    frame.header_word_three = $urandom();
                    frame.header_word_four  = $urandom();
                    frame.header_word_five  = $urandom();
                    frame.strength_raw      = $urandom();
                end
                else if (pick >= 80)
                    frame = build_frame(beacon_type_model ^ 16'($urandom_range(1, 65535)),
                                        beam, stamp, strength);
                else
                    frame = build_frame(beacon_type_model, beam, stamp, strength);
                send_frame(frame);
            end
            wait_for_results();
        end
        in_gap_max = 4;
        out_gap_max = 4;
    endtask

    initial
    begin
        beacon_type_model = pbssr_pkg::BEACON_TYPE_RESET;
        for (int b = 0; b < BEAM_COUNT; b++)
        begin
            stamp_model[b] = '0;
            count_model[b] = '0;
            head_model[b] = '0;
        end
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_field_extremes();
        test_ring_wrap();
        test_type_register();
        test_random_traffic();
        wait_for_results();
        repeat (10) @(posedge clk);
        $display("Run covered %0d frames: %0d recorded, %0d duplicates, %0d ignored.",
                 recorded_total + duplicate_total + ignored_total,
                 recorded_total, duplicate_total, ignored_total);
        $display("The frame type register took %0d settings.", type_settings);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
